/* sv/assert_macros.svh */
// Assertion macros for the checker file of the line fit block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("line fit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("line fit assertion failed");

`endif

/* sv/lsf_pkg.sv */
// Types and constants shared by the least squares line fit modules.
`default_nettype none

package lsf_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int CNT_W       = $clog2(MAX_POINTS + 2);
	localparam int LOG_N       = $clog2(MAX_POINTS);
	localparam int SX_W        = 16 + LOG_N;
	localparam int SXX_W       = 32 + LOG_N;
	localparam int D_W         = CNT_W + SXX_W + 1;
	localparam int NUM_W       = SX_W + 33;
	localparam int DIV_W       = D_W + 17;
	localparam int DCNT_W      = $clog2(DIV_W);
	localparam int Q_W         = 33;
	localparam int MA_W        = (SXX_W >= 35) ? SXX_W : 35;
	localparam int MB_W        = (SX_W >= 33) ? SX_W : 33;
	localparam int P_W         = MA_W + MB_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_X_FLAT   = 2'd1,
		ST_Y_FLAT   = 2'd2,
		ST_TOO_MANY = 2'd3
	} fit_status_t;

	typedef struct packed {
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic               last_point;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
		logic signed [15:0] correlation;
		fit_status_t        fit_status;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]        n;
		logic signed [SX_W-1:0]  sx;
		logic signed [SX_W-1:0]  sy;
		logic signed [SXX_W-1:0] sxy;
		logic signed [SXX_W-1:0] sxx;
		logic signed [SXX_W-1:0] syy;
	} sums_t;

endpackage

`default_nettype wire

/* sv/lsf_front.sv */
// Front end: accepts samples and accumulates the point count and the five sums.
`default_nettype none

module lsf_front import lsf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  sample_t sample,
	input  logic    full,
	output logic    push,
	output sums_t   sums
);

	sums_t              sums_q;
	sums_t              nxt;
	logic               accept;
	logic signed [31:0] pxy;
	logic signed [31:0] pxx;
	logic signed [31:0] pyy;

	assign accept = start && !full;
	assign pxy    = sample.sample_x * sample.sample_y;
	assign pxx    = sample.sample_x * sample.sample_x;
	assign pyy    = sample.sample_y * sample.sample_y;

	always_comb begin
		nxt = sums_q;
		if (sums_q.n < CNT_W'(MAX_POINTS)) begin
			nxt.n   = sums_q.n + 1'b1;
			nxt.sx  = sums_q.sx + {{(SX_W-16){sample.sample_x[15]}}, sample.sample_x};
			nxt.sy  = sums_q.sy + {{(SX_W-16){sample.sample_y[15]}}, sample.sample_y};
			nxt.sxy = sums_q.sxy + {{(SXX_W-32){pxy[31]}}, pxy};
			nxt.sxx = sums_q.sxx + {{(SXX_W-32){pxx[31]}}, pxx};
			nxt.syy = sums_q.syy + {{(SXX_W-32){pyy[31]}}, pyy};
		end else begin
			nxt.n = CNT_W'(MAX_POINTS + 1);
		end
	end

	assign push = accept && sample.last_point;
	assign sums = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (accept) begin
			if (sample.last_point) begin
				sums_q <= '0;
			end else begin
				sums_q <= nxt;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/lsf_queue.sv */
// Short queue of completed point sets between the front end and the back end.
`default_nettype none

module lsf_queue import lsf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  sums_t din,
	input  logic  pop,
	output sums_t dout,
	output logic  full,
	output logic  empty
);

	sums_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/lsf_back.sv */
// Back end: sequencer that turns a point set into slope, intercept, correlation and a fit status.
`default_nettype none

module lsf_back import lsf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    empty,
	input  sums_t   sums,
	output logic    pop,
	output logic    done,
	output result_t result
);

	typedef enum logic [22:0] {
		S_IDLE  = 23'h000001,
		S_M1    = 23'h000002,
		S_M2    = 23'h000004,
		S_M3    = 23'h000008,
		S_M4    = 23'h000010,
		S_M5    = 23'h000020,
		S_M6    = 23'h000040,
		S_M7    = 23'h000080,
		S_SDIV  = 23'h000100,
		S_SLOPE = 23'h000200,
		S_IM    = 23'h000400,
		S_IN    = 23'h000800,
		S_IDIV  = 23'h001000,
		S_ICPT  = 23'h002000,
		S_CN    = 23'h004000,
		S_CP1   = 23'h008000,
		S_CP2   = 23'h010000,
		S_CP3   = 23'h020000,
		S_CB1   = 23'h040000,
		S_CB2   = 23'h080000,
		S_CB3   = 23'h100000,
		S_CB4   = 23'h200000,
		S_CORR  = 23'h400000
	} state_t;

	localparam logic [Q_W-1:0] Q_LIM = Q_W'(64'h8000_0000);

	state_t                  state_q;
	sums_t                   sums_q;
	logic signed [D_W-1:0]   t_q;
	logic signed [D_W-1:0]   dx_q;
	logic signed [D_W-1:0]   dy_q;
	logic                    nxy_neg_q;
	logic [D_W-1:0]          a_q;
	logic signed [31:0]      slope_q;
	logic signed [31:0]      icpt_q;
	logic                    num_neg_q;
	logic [D_W-1:0]          div_rem_q;
	logic [DIV_W-1:0]        div_num_q;
	logic [D_W-1:0]          div_den_q;
	logic [Q_W-1:0]          div_quo_q;
	logic                    div_sat_q;
	logic [DCNT_W-1:0]       div_cnt_q;
	logic [D_W-1:0]          ux_q;
	logic [D_W-1:0]          uy_q;
	logic [59:0]             p_q;
	logic [63:0]             sq_q;
	logic [33:0]             c2_q;
	logic [63:0]             lo_q;
	logic [15:0]             cq_q;
	logic [3:0]              bit_q;
	logic signed [P_W-1:0]   prod_q;
	logic                    done_q;
	result_t                 res_q;

	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [D_W-1:0]   prod_d;
	logic signed [D_W-1:0]   nxy_c;
	logic [D_W-1:0]          nxy_mag;
	logic [D_W:0]            rem2;
	logic                    div_ge;
	logic                    div_last;
	logic [Q_W:0]            qp1;
	logic signed [NUM_W-1:0] num_c;
	logic [NUM_W-1:0]        num_mag;
	logic signed [31:0]      icpt_c;
	logic                    shx;
	logic                    shy;
	logic [15:0]             bit_mask;
	logic [15:0]             t_c;
	logic [16:0]             c_c;
	logic [95:0]             lhs;
	logic [95:0]             rhs;
	logic [15:0]             q_cap;
	logic signed [15:0]      corr_c;

	function automatic logic [31:0] cap31(input logic s, input logic [Q_W-1:0] v);
		logic [31:0] r;
		if (s || v >= Q_LIM) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic neg, input logic [31:0] m);
		logic signed [31:0] r;
		if (neg) begin
			r = m[31] ? 32'sh8000_0000 : -$signed(m);
		end else begin
			r = (m >= 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m);
		end
		return r;
	endfunction

	assign prod_d   = $signed(prod_q[D_W-1:0]);
	assign nxy_c    = t_q - prod_d;
	assign nxy_mag  = nxy_c[D_W-1] ? D_W'(-nxy_c) : D_W'(nxy_c);
	assign rem2     = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_ge   = rem2 >= {1'b0, div_den_q};
	assign div_last = (div_cnt_q == DCNT_W'(DIV_W - 1));
	assign qp1      = {1'b0, div_quo_q} + 1'b1;
	assign num_c    = (NUM_W'(sums_q.sy) <<< 16) - $signed(prod_q[NUM_W-1:0]);
	assign num_mag  = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
	assign icpt_c   = sat32(num_neg_q, cap31(div_sat_q, div_quo_q));
	assign shx      = |ux_q[D_W-1:30];
	assign shy      = |uy_q[D_W-1:30];
	assign bit_mask = 16'd1 << bit_q;
	assign t_c      = cq_q | bit_mask;
	assign c_c      = {t_c, 1'b0} - 17'd1;
	assign lhs      = {2'b00, prod_q[63:0], 30'd0} + {32'd0, lo_q};
	assign rhs      = {sq_q, 32'd0};
	assign q_cap    = (cq_q > 16'd32768) ? 16'd32768 : cq_q;
	assign corr_c   = nxy_neg_q ? -$signed(q_cap)
		: ((q_cap == 16'd32768) ? 16'sd32767 : $signed(q_cap));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M1: begin
				mul_a = MA_W'(sums_q.sxx);
				mul_b = MB_W'(sums_q.n);
			end
			S_M2: begin
				mul_a = MA_W'(sums_q.sx);
				mul_b = MB_W'(sums_q.sx);
			end
			S_M3: begin
				mul_a = MA_W'(sums_q.syy);
				mul_b = MB_W'(sums_q.n);
			end
			S_M4: begin
				mul_a = MA_W'(sums_q.sy);
				mul_b = MB_W'(sums_q.sy);
			end
			S_M5: begin
				mul_a = MA_W'(sums_q.sxy);
				mul_b = MB_W'(sums_q.n);
			end
			S_M6: begin
				mul_a = MA_W'(sums_q.sx);
				mul_b = MB_W'(sums_q.sy);
			end
			S_IM: begin
				mul_a = MA_W'(slope_q);
				mul_b = MB_W'(sums_q.sx);
			end
			S_CP1: begin
				mul_a = MA_W'(ux_q[29:0]);
				mul_b = MB_W'(uy_q[29:0]);
			end
			S_CP2: begin
				mul_a = MA_W'(a_q[31:0]);
				mul_b = MB_W'(a_q[31:0]);
			end
			S_CB1: begin
				mul_a = MA_W'(c_c);
				mul_b = MB_W'(c_c);
			end
			S_CB2: begin
				mul_a = MA_W'(prod_q[33:0]);
				mul_b = MB_W'(p_q[29:0]);
			end
			S_CB3: begin
				mul_a = MA_W'(c2_q);
				mul_b = MB_W'(p_q[59:30]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign pop    = (state_q == S_IDLE) && !empty;
	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				sums_q <= sums;
			end
			S_M2, S_M4, S_M6: begin
				t_q <= prod_d;
			end
			S_M3: begin
				dx_q <= t_q - prod_d;
			end
			S_M5: begin
				dy_q <= t_q - prod_d;
			end
			S_M7: begin
				nxy_neg_q <= nxy_c[D_W-1];
				a_q       <= nxy_mag;
				div_num_q <= {nxy_mag, 17'd0};
				div_den_q <= D_W'(dx_q);
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_sat_q <= 1'b0;
				div_cnt_q <= '0;
			end
			S_SDIV, S_IDIV: begin
				div_rem_q <= div_ge ? D_W'(rem2 - {1'b0, div_den_q}) : D_W'(rem2);
				div_num_q <= div_num_q << 1;
				div_quo_q <= {div_quo_q[Q_W-2:0], div_ge};
				div_sat_q <= div_sat_q | div_quo_q[Q_W-1];
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			S_SLOPE: begin
				slope_q <= sat32(nxy_neg_q, cap31(div_sat_q, qp1[Q_W:1]));
			end
			S_IN: begin
				num_neg_q <= num_c[NUM_W-1];
				div_num_q <= DIV_W'(num_mag) + DIV_W'({sums_q.n, 7'd0});
				div_den_q <= D_W'({sums_q.n, 8'd0});
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_sat_q <= 1'b0;
				div_cnt_q <= '0;
			end
			S_ICPT: begin
				icpt_q <= icpt_c;
				ux_q   <= D_W'(dx_q);
				uy_q   <= D_W'(dy_q);
			end
			S_CN: begin
				if (shx) begin
					ux_q <= ux_q >> 2;
				end
				if (shy) begin
					uy_q <= uy_q >> 2;
				end
				a_q <= a_q >> ({1'b0, shx} + {1'b0, shy});
			end
			S_CP1: begin
				if (|a_q[D_W-1:32]) begin
					a_q <= D_W'(33'h0_FFFF_FFFF);
				end
			end
			S_CP2: begin
				p_q <= prod_q[59:0];
			end
			S_CP3: begin
				sq_q <= prod_q[63:0];
			end
			S_CB2: begin
				c2_q <= prod_q[33:0];
			end
			S_CB3: begin
				lo_q <= prod_q[63:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			res_q   <= '0;
			cq_q    <= '0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: state_q <= S_M6;
				S_M6: state_q <= S_M7;
				S_M7: begin
					if (sums_q.n > CNT_W'(MAX_POINTS)) begin
						res_q   <= '{slope: '0, intercept: '0, correlation: '0,
							fit_status: ST_TOO_MANY};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (dx_q <= 0) begin
						res_q   <= '{slope: '0, intercept: '0, correlation: '0,
							fit_status: ST_X_FLAT};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (div_last) begin
						state_q <= S_SLOPE;
					end
				end
				S_SLOPE: state_q <= S_IM;
				S_IM:    state_q <= S_IN;
				S_IN:    state_q <= S_IDIV;
				S_IDIV: begin
					if (div_last) begin
						state_q <= S_ICPT;
					end
				end
				S_ICPT: begin
					if (dy_q <= 0) begin
						res_q   <= '{slope: slope_q, intercept: icpt_c, correlation: '0,
							fit_status: ST_Y_FLAT};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CN;
					end
				end
				S_CN: begin
					if (!shx && !shy) begin
						state_q <= S_CP1;
					end
				end
				S_CP1: state_q <= S_CP2;
				S_CP2: state_q <= S_CP3;
				S_CP3: begin
					cq_q    <= '0;
					bit_q   <= 4'd15;
					state_q <= S_CB1;
				end
				S_CB1: state_q <= S_CB2;
				S_CB2: state_q <= S_CB3;
				S_CB3: state_q <= S_CB4;
				S_CB4: begin
					if (lhs <= rhs) begin
						cq_q <= t_c;
					end
					if (bit_q == '0) begin
						state_q <= S_CORR;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_CB1;
					end
				end
				S_CORR: begin
					res_q   <= '{slope: slope_q, intercept: icpt_q, correlation: corr_c,
						fit_status: ST_OK};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/least_squares_line_fit.sv */
// Top level of the streaming least squares line fit with correlation.
// Samples are taken one per cycle while the queue has room; busy is high when it is full.
// With the back end idle, a rejected or x flat set gets its result once the multiply states are through,
// a y flat set once the two 63-step dividers have also given slope and intercept, and any other set
// after up to seven normalization steps and a 16-step correlation search, each step in S_CB1 to S_CB4.
// Reset is asynchronous and clears the sums, the queue and the sequencer; the receiver cannot stall.
`default_nettype none

module least_squares_line_fit import lsf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  sample_t sample,
	output logic    done,
	output result_t result
);

	logic  full;
	logic  empty;
	logic  push;
	logic  pop;
	sums_t front_sums;
	sums_t queue_sums;

	assign busy = full;

	lsf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sample (sample),
		.full   (full),
		.push   (push),
		.sums   (front_sums)
	);

	lsf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_sums),
		.pop    (pop),
		.dout   (queue_sums),
		.full   (full),
		.empty  (empty)
	);

	lsf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.sums   (queue_sums),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

/* sv/lsf_checker.sv */
// Port level checker for the line fit block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lsf_checker import lsf_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	logic zero_fields;
	logic is_many;
	logic is_xflat;
	logic is_yflat;

	assign zero_fields = result.slope == 0 && result.intercept == 0 && result.correlation == 0;
	assign is_many     = done && result.fit_status == ST_TOO_MANY;
	assign is_xflat    = done && result.fit_status == ST_X_FLAT;
	assign is_yflat    = done && result.fit_status == ST_Y_FLAT;

	`LSF_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`LSF_ASSERT_IMPLY(a_many_zero, clk, arst_n, is_many, zero_fields)
	`LSF_ASSERT_IMPLY(a_xflat_zero, clk, arst_n, is_xflat, zero_fields)
	`LSF_ASSERT_IMPLY(a_yflat_corr, clk, arst_n, is_yflat, result.correlation == 0)
	`LSF_ASSERT_IMPLY(a_known, clk, arst_n, 1'b1, !$isunknown({start, busy, done}))

endmodule

bind least_squares_line_fit lsf_checker u_lsf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
